// ----- sv/ucs_pkg.sv -----
`default_nettype none

package ucs_pkg;

    // default width of the byte position counter
    localparam int POSITION_BITS_DEFAULT = 16;

    // default depth of the command queue between the lexer and the emitter
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // width of the token offset and length fields on the result channel
    localparam int TOKEN_BITS = 16;

    // input operations
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // delimiter characters
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_COLON    = 8'h3A;

    // lexer modes
    typedef enum logic [2:0] {
        MODE_SCHEME      = 3'd0,
        MODE_AFTER_COLON = 3'd1,
        MODE_SLASH1      = 3'd2,
        MODE_AUTHORITY   = 3'd3,
        MODE_PATH        = 3'd4,
        MODE_QUERY       = 3'd5,
        MODE_FRAGMENT    = 3'd6,
        MODE_DEAD        = 3'd7
    } lex_mode_t;

    // token types
    typedef enum logic [3:0] {
        TOK_SCHEME   = 4'd0,
        TOK_USER     = 4'd1,
        TOK_PASSWORD = 4'd2,
        TOK_HOST     = 4'd3,
        TOK_PORT     = 4'd4,
        TOK_PATH     = 4'd5,
        TOK_QUERY    = 4'd6,
        TOK_FRAGMENT = 4'd7,
        TOK_END      = 4'd8
    } token_type_t;

    // result slots of one command, emitted lowest first
    localparam int SLOT_FIRST    = 0;
    localparam int SLOT_PASSWORD = 1;
    localparam int SLOT_HOST     = 2;
    localparam int SLOT_PORT     = 3;
    localparam int SLOT_END      = 4;
    localparam int NUM_SLOTS     = 5;
    localparam int SEL_BITS      = $clog2(NUM_SLOTS);

    // positions carried by one command
    localparam int IX_AUTH_BEGIN = 0;
    localparam int IX_AT         = 1;
    localparam int IX_COLON_ANY  = 2;
    localparam int IX_COLON_AT   = 3;
    localparam int IX_TOK_BEGIN  = 4;
    localparam int IX_TOK_END    = 5;
    localparam int IX_END_POS    = 6;
    localparam int NUM_POS       = 7;

    // control part of a command
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        token_type_t          tok_type;
        logic                 is_auth;
        logic                 at_v;
        logic                 ovf;
    } cmd_ctl_t;

endpackage

`default_nettype wire

// ----- sv/ucs_front.sv -----
`default_nettype none

module ucs_front #(
    parameter int POSITION_BITS = ucs_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   op,
    input  wire logic [7:0]             char_in,
    input  wire logic                   q_full,
    output logic                        push,
    output ucs_pkg::cmd_ctl_t           cmd_ctl,
    output logic [ucs_pkg::NUM_POS-1:0][POSITION_BITS-1:0] cmd_pos
);

    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;

    ucs_pkg::lex_mode_t mode_reg, mode_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [PB-1:0] tb_reg, tb_next;
    logic [PB-1:0] ab_reg, ab_next;
    logic          at_v_reg, at_v_next;
    logic [PB-1:0] at_reg, at_next;
    logic          cany_v_reg, cany_v_next;
    logic [PB-1:0] cany_reg, cany_next;
    logic          cat_v_reg, cat_v_next;
    logic [PB-1:0] cat_reg, cat_next;
    logic          ovf_reg, ovf_next;

    logic          accept;
    logic          is_end;
    logic [PB-1:0] nx;
    logic [ucs_pkg::NUM_SLOTS-1:0] auth_mask;
    logic          at_eff;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] x);
        return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    // input handshake
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_end   = (op == ucs_pkg::OP_END);
    assign nx       = sat_inc(pos_reg);

    // which authority tokens exist, from the recorded boundaries
    always_comb
    begin
        at_eff    = at_v_reg && (at_reg > ab_reg);
        auth_mask = '0;
        auth_mask[ucs_pkg::SLOT_FIRST]    = at_eff;
        auth_mask[ucs_pkg::SLOT_PASSWORD] = at_eff && cany_v_reg && (cany_reg < at_reg);
        auth_mask[ucs_pkg::SLOT_HOST]     = 1'b1;
        auth_mask[ucs_pkg::SLOT_PORT]     = at_v_reg ? cat_v_reg : cany_v_reg;
    end

    // next lexer mode
    always_comb
    begin
        mode_next = mode_reg;
        if (accept)
        begin
            if (is_end)
            begin
                mode_next = ucs_pkg::MODE_SCHEME;
            end
            else
            begin
                unique case (mode_reg)
                    ucs_pkg::MODE_SCHEME:
                    begin
                        if (char_in == ucs_pkg::CH_COLON)
                            mode_next = ucs_pkg::MODE_AFTER_COLON;
                    end
                    ucs_pkg::MODE_AFTER_COLON:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH)
                            mode_next = ucs_pkg::MODE_SLASH1;
                        else if (char_in == ucs_pkg::CH_QUESTION)
                            mode_next = ucs_pkg::MODE_QUERY;
                        else if (char_in == ucs_pkg::CH_HASH)
                            mode_next = ucs_pkg::MODE_FRAGMENT;
                        else
                            mode_next = ucs_pkg::MODE_DEAD;
                    end
                    ucs_pkg::MODE_SLASH1:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH)
                            mode_next = ucs_pkg::MODE_AUTHORITY;
                        else if (char_in == ucs_pkg::CH_QUESTION)
                            mode_next = ucs_pkg::MODE_QUERY;
                        else if (char_in == ucs_pkg::CH_HASH)
                            mode_next = ucs_pkg::MODE_FRAGMENT;
                        else
                            mode_next = ucs_pkg::MODE_PATH;
                    end
                    ucs_pkg::MODE_AUTHORITY:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH)
                            mode_next = ucs_pkg::MODE_PATH;
                        else if (char_in == ucs_pkg::CH_QUESTION)
                            mode_next = ucs_pkg::MODE_QUERY;
                        else if (char_in == ucs_pkg::CH_HASH)
                            mode_next = ucs_pkg::MODE_FRAGMENT;
                    end
                    ucs_pkg::MODE_PATH:
                    begin
                        if (char_in == ucs_pkg::CH_QUESTION)
                            mode_next = ucs_pkg::MODE_QUERY;
                        else if (char_in == ucs_pkg::CH_HASH)
                            mode_next = ucs_pkg::MODE_FRAGMENT;
                    end
                    ucs_pkg::MODE_QUERY:
                    begin
                        if (char_in == ucs_pkg::CH_HASH)
                            mode_next = ucs_pkg::MODE_FRAGMENT;
                    end
                    ucs_pkg::MODE_FRAGMENT,
                    ucs_pkg::MODE_DEAD:
                    begin
                        mode_next = mode_reg;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    // position and boundary registers
    always_comb
    begin
        pos_next    = pos_reg;
        tb_next     = tb_reg;
        ab_next     = ab_reg;
        at_v_next   = at_v_reg;
        at_next     = at_reg;
        cany_v_next = cany_v_reg;
        cany_next   = cany_reg;
        cat_v_next  = cat_v_reg;
        cat_next    = cat_reg;
        ovf_next    = ovf_reg;
        if (accept)
        begin
            if (is_end)
            begin
                pos_next    = '0;
                tb_next     = '0;
                ab_next     = '0;
                at_v_next   = 1'b0;
                at_next     = '0;
                cany_v_next = 1'b0;
                cany_next   = '0;
                cat_v_next  = 1'b0;
                cat_next    = '0;
                ovf_next    = 1'b0;
            end
            else
            begin
                pos_next = nx;
                if (pos_reg == POS_MAX)
                    ovf_next = 1'b1;
                unique case (mode_reg)
                    ucs_pkg::MODE_AFTER_COLON:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH)
                            tb_next = pos_reg;
                        else if (char_in == ucs_pkg::CH_QUESTION
                                 || char_in == ucs_pkg::CH_HASH)
                            tb_next = nx;
                    end
                    ucs_pkg::MODE_SLASH1:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH)
                        begin
                            ab_next     = nx;
                            at_v_next   = 1'b0;
                            at_next     = '0;
                            cany_v_next = 1'b0;
                            cany_next   = '0;
                            cat_v_next  = 1'b0;
                            cat_next    = '0;
                        end
                        else if (char_in == ucs_pkg::CH_QUESTION
                                 || char_in == ucs_pkg::CH_HASH)
                        begin
                            tb_next = nx;
                        end
                    end
                    ucs_pkg::MODE_AUTHORITY:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH)
                        begin
                            tb_next = pos_reg;
                        end
                        else if (char_in == ucs_pkg::CH_QUESTION
                                 || char_in == ucs_pkg::CH_HASH)
                        begin
                            tb_next = nx;
                        end
                        else if (char_in == ucs_pkg::CH_AT)
                        begin
                            at_v_next  = 1'b1;
                            at_next    = pos_reg;
                            cat_v_next = 1'b0;
                            cat_next   = '0;
                        end
                        else if (char_in == ucs_pkg::CH_COLON)
                        begin
                            if (!cany_v_reg)
                            begin
                                cany_v_next = 1'b1;
                                cany_next   = pos_reg;
                            end
                            if (at_v_reg && !cat_v_reg)
                            begin
                                cat_v_next = 1'b1;
                                cat_next   = pos_reg;
                            end
                        end
                    end
                    ucs_pkg::MODE_PATH:
                    begin
                        if (char_in == ucs_pkg::CH_QUESTION
                            || char_in == ucs_pkg::CH_HASH)
                            tb_next = nx;
                    end
                    ucs_pkg::MODE_QUERY:
                    begin
                        if (char_in == ucs_pkg::CH_HASH)
                            tb_next = nx;
                    end
                    default:
                    begin
                        tb_next = tb_reg;
                    end
                endcase
            end
        end
    end

    // command to the emitter
    always_comb
    begin
        push             = 1'b0;
        cmd_ctl.mask     = '0;
        cmd_ctl.tok_type = ucs_pkg::TOK_PATH;
        cmd_ctl.is_auth  = 1'b0;
        cmd_ctl.at_v     = at_v_reg;
        cmd_ctl.ovf      = ovf_reg;
        cmd_pos[ucs_pkg::IX_AUTH_BEGIN] = ab_reg;
        cmd_pos[ucs_pkg::IX_AT]         = at_reg;
        cmd_pos[ucs_pkg::IX_COLON_ANY]  = cany_reg;
        cmd_pos[ucs_pkg::IX_COLON_AT]   = cat_reg;
        cmd_pos[ucs_pkg::IX_TOK_BEGIN]  = tb_reg;
        cmd_pos[ucs_pkg::IX_TOK_END]    = pos_reg;
        cmd_pos[ucs_pkg::IX_END_POS]    = pos_reg;
        if (accept)
        begin
            if (is_end)
            begin
                push = 1'b1;
                cmd_ctl.mask[ucs_pkg::SLOT_END] = 1'b1;
                unique case (mode_reg)
                    ucs_pkg::MODE_SCHEME:
                    begin
                        cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                        cmd_ctl.tok_type = ucs_pkg::TOK_SCHEME;
                        cmd_pos[ucs_pkg::IX_TOK_BEGIN] = '0;
                    end
                    ucs_pkg::MODE_SLASH1:
                    begin
                        cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                        cmd_ctl.tok_type = ucs_pkg::TOK_PATH;
                        cmd_pos[ucs_pkg::IX_TOK_END] = sat_inc(tb_reg);
                    end
                    ucs_pkg::MODE_AUTHORITY:
                    begin
                        cmd_ctl.mask    = auth_mask;
                        cmd_ctl.mask[ucs_pkg::SLOT_END] = 1'b1;
                        cmd_ctl.is_auth = 1'b1;
                    end
                    ucs_pkg::MODE_PATH:
                    begin
                        cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                        cmd_ctl.tok_type = ucs_pkg::TOK_PATH;
                    end
                    ucs_pkg::MODE_QUERY:
                    begin
                        cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                        cmd_ctl.tok_type = ucs_pkg::TOK_QUERY;
                    end
                    ucs_pkg::MODE_FRAGMENT:
                    begin
                        cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                        cmd_ctl.tok_type = ucs_pkg::TOK_FRAGMENT;
                    end
                    default:
                    begin
                        cmd_ctl.tok_type = ucs_pkg::TOK_END;
                    end
                endcase
            end
            else
            begin
                unique case (mode_reg)
                    ucs_pkg::MODE_SCHEME:
                    begin
                        if (char_in == ucs_pkg::CH_COLON)
                        begin
                            push = 1'b1;
                            cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                            cmd_ctl.tok_type = ucs_pkg::TOK_SCHEME;
                            cmd_pos[ucs_pkg::IX_TOK_BEGIN] = '0;
                        end
                    end
                    ucs_pkg::MODE_SLASH1,
                    ucs_pkg::MODE_PATH:
                    begin
                        if (char_in == ucs_pkg::CH_QUESTION || char_in == ucs_pkg::CH_HASH)
                        begin
                            push = 1'b1;
                            cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                            cmd_ctl.tok_type = ucs_pkg::TOK_PATH;
                        end
                    end
                    ucs_pkg::MODE_AUTHORITY:
                    begin
                        if (char_in == ucs_pkg::CH_SLASH || char_in == ucs_pkg::CH_QUESTION
                            || char_in == ucs_pkg::CH_HASH)
                        begin
                            push            = 1'b1;
                            cmd_ctl.mask    = auth_mask;
                            cmd_ctl.is_auth = 1'b1;
                        end
                    end
                    ucs_pkg::MODE_QUERY:
                    begin
                        if (char_in == ucs_pkg::CH_HASH)
                        begin
                            push = 1'b1;
                            cmd_ctl.mask[ucs_pkg::SLOT_FIRST] = 1'b1;
                            cmd_ctl.tok_type = ucs_pkg::TOK_QUERY;
                        end
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ucs_pkg::MODE_SCHEME;
            pos_reg    <= '0;
            tb_reg     <= '0;
            ab_reg     <= '0;
            at_v_reg   <= 1'b0;
            at_reg     <= '0;
            cany_v_reg <= 1'b0;
            cany_reg   <= '0;
            cat_v_reg  <= 1'b0;
            cat_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tb_reg     <= tb_next;
            ab_reg     <= ab_next;
            at_v_reg   <= at_v_next;
            at_reg     <= at_next;
            cany_v_reg <= cany_v_next;
            cany_reg   <= cany_next;
            cat_v_reg  <= cat_v_next;
            cat_reg    <= cat_next;
            ovf_reg    <= ovf_next;
        end
    end

    // an end transaction leaves the lexer ready for a fresh url
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |=> (mode_reg == ucs_pkg::MODE_SCHEME && pos_reg == '0
                                && !ovf_reg && !at_v_reg))
        else $error("lexer state not cleared after end transaction");

endmodule

`default_nettype wire

// ----- sv/ucs_queue.sv -----
`default_nettype none

module ucs_queue #(
    parameter int DEPTH      = ucs_pkg::QUEUE_DEPTH_DEFAULT,
    parameter int DATA_BITS  = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [DATA_BITS-1:0] push_data,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      not_empty,
    output logic [DATA_BITS-1:0]      head
);

    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0]  mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  do_push;
    logic                  do_pop;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == COUNT_BITS'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // the lexer only pushes when there is room
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

// ----- sv/ucs_back.sv -----
`default_nettype none

module ucs_back #(
    parameter int POSITION_BITS = ucs_pkg::POSITION_BITS_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_pop,
    input  wire ucs_pkg::cmd_ctl_t    cmd_ctl,
    input  wire logic [ucs_pkg::NUM_POS-1:0][POSITION_BITS-1:0] cmd_pos,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [3:0]                token_type,
    output logic [ucs_pkg::TOKEN_BITS-1:0] token_start,
    output logic [ucs_pkg::TOKEN_BITS-1:0] token_length,
    output logic                      overflow,
    output logic                      last
);

    localparam int PB = POSITION_BITS;
    localparam int TB = ucs_pkg::TOKEN_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;

    logic [ucs_pkg::NUM_SLOTS-1:0] mask_reg, mask_next, mask_after;
    ucs_pkg::cmd_ctl_t             ctl_reg;
    logic [ucs_pkg::NUM_POS-1:0][PB-1:0] pos_reg;

    logic                          out_valid_reg, out_valid_next;
    ucs_pkg::token_type_t          type_reg;
    logic [TB-1:0]                 start_reg;
    logic [TB-1:0]                 length_reg;
    logic                          ovf_reg;
    logic                          last_reg;

    logic [ucs_pkg::SEL_BITS-1:0]  sel;
    logic                          emit;
    ucs_pkg::token_type_t          sel_type;
    logic [PB-1:0]                 sel_begin;
    logic [PB-1:0]                 sel_end;
    logic [PB-1:0]                 sel_len;
    logic [PB-1:0]                 hp_colon;
    logic [PB+TB-1:0]              start_wide;
    logic [PB+TB-1:0]              len_wide;

    function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] x);
        return (x == POS_MAX) ? x : x + 1'b1;
    endfunction

    // lowest pending slot goes out first
    always_comb
    begin
        sel = '0;
        for (int i = ucs_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = ucs_pkg::SEL_BITS'(i);
        end
    end

    assign emit       = (mask_reg != '0) && (!out_valid_reg || !out_stall);
    assign mask_after = emit ? (mask_reg & ~(ucs_pkg::NUM_SLOTS'(1) << sel)) : mask_reg;
    assign cmd_pop    = (mask_after == '0) && cmd_valid;
    assign mask_next  = cmd_pop ? cmd_ctl.mask : mask_after;

    // token type and extent of the selected slot
    always_comb
    begin
        hp_colon = ctl_reg.at_v ? pos_reg[ucs_pkg::IX_COLON_AT]
                                : pos_reg[ucs_pkg::IX_COLON_ANY];
        unique case (sel)
            ucs_pkg::SEL_BITS'(ucs_pkg::SLOT_FIRST):
            begin
                if (ctl_reg.is_auth)
                begin
                    sel_type  = ucs_pkg::TOK_USER;
                    sel_begin = pos_reg[ucs_pkg::IX_AUTH_BEGIN];
                    sel_end   = ctl_reg.mask[ucs_pkg::SLOT_PASSWORD]
                                ? pos_reg[ucs_pkg::IX_COLON_ANY] : pos_reg[ucs_pkg::IX_AT];
                end
                else
                begin
                    sel_type  = ctl_reg.tok_type;
                    sel_begin = pos_reg[ucs_pkg::IX_TOK_BEGIN];
                    sel_end   = pos_reg[ucs_pkg::IX_TOK_END];
                end
            end
            ucs_pkg::SEL_BITS'(ucs_pkg::SLOT_PASSWORD):
            begin
                sel_type  = ucs_pkg::TOK_PASSWORD;
                sel_begin = sat_inc(pos_reg[ucs_pkg::IX_COLON_ANY]);
                sel_end   = pos_reg[ucs_pkg::IX_AT];
            end
            ucs_pkg::SEL_BITS'(ucs_pkg::SLOT_HOST):
            begin
                sel_type  = ucs_pkg::TOK_HOST;
                sel_begin = ctl_reg.at_v ? sat_inc(pos_reg[ucs_pkg::IX_AT])
                                         : pos_reg[ucs_pkg::IX_AUTH_BEGIN];
                sel_end   = ctl_reg.mask[ucs_pkg::SLOT_PORT]
                            ? hp_colon : pos_reg[ucs_pkg::IX_TOK_END];
            end
            ucs_pkg::SEL_BITS'(ucs_pkg::SLOT_PORT):
            begin
                sel_type  = ucs_pkg::TOK_PORT;
                sel_begin = sat_inc(hp_colon);
                sel_end   = pos_reg[ucs_pkg::IX_TOK_END];
            end
            default:
            begin
                sel_type  = ucs_pkg::TOK_END;
                sel_begin = pos_reg[ucs_pkg::IX_END_POS];
                sel_end   = pos_reg[ucs_pkg::IX_END_POS];
            end
        endcase
        sel_len    = (sel_end >= sel_begin) ? (sel_end - sel_begin) : '0;
        start_wide = (PB + TB)'(sel_begin);
        len_wide   = (PB + TB)'(sel_len);
    end

    // output register valid
    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ctl_reg <= cmd_ctl;
            pos_reg <= cmd_pos;
        end
        if (emit)
        begin
            type_reg   <= sel_type;
            start_reg  <= start_wide[TB-1:0];
            length_reg <= len_wide[TB-1:0];
            ovf_reg    <= ctl_reg.ovf;
            last_reg   <= (mask_after == '0);
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_type   = type_reg;
    assign token_start  = start_reg;
    assign token_length = length_reg;
    assign overflow     = ovf_reg;
    assign last         = last_reg;

    // the end token always closes its transaction
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && type_reg == ucs_pkg::TOK_END) |-> last_reg)
        else $error("end token without last");

    // nothing goes out once the current command and the queue are drained
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && mask_reg == '0 && !cmd_valid) |=> !out_valid_reg)
        else $error("result shown with no pending command");

    // a new command is loaded only when the current one is spent
    a_pop_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (mask_reg == '0 || (emit && $countones(mask_reg) == 1)))
        else $error("command loaded over unfinished results");

endmodule

`default_nettype wire

// ----- sv/url_component_splitter.sv -----
`default_nettype none

// Streaming URL tokenizer. One byte (op = 0) or the end mark (op = 1) is taken per cycle
// with no gap between transactions while the command queue is not full; the lexer tracks
// scheme, authority boundaries ('@' and colons), path, query and fragment in registers
// and, for each transaction that closes tokens, pushes one command into a QUEUE_DEPTH-entry
// command queue. The emitter expands a command into one to five token descriptors, one per
// cycle while out_stall is low, through an output register; in_stall rises only while the
// command queue is full. Offsets saturate at 2^POSITION_BITS - 1 and then set overflow, and
// the end mark emits an end token and returns the lexer to its reset state.
module url_component_splitter #(
    parameter int POSITION_BITS = ucs_pkg::POSITION_BITS_DEFAULT,
    parameter int QUEUE_DEPTH   = ucs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  char_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       token_type,
    output logic [ucs_pkg::TOKEN_BITS-1:0] token_start,
    output logic [ucs_pkg::TOKEN_BITS-1:0] token_length,
    output logic             overflow,
    output logic             last
);

    localparam int POS_VEC_BITS = ucs_pkg::NUM_POS * POSITION_BITS;
    localparam int CMD_BITS     = $bits(ucs_pkg::cmd_ctl_t) + POS_VEC_BITS;

    logic                                            push;
    ucs_pkg::cmd_ctl_t                               front_ctl;
    logic [ucs_pkg::NUM_POS-1:0][POSITION_BITS-1:0]  front_pos;
    logic                                            q_full;
    logic                                            q_not_empty;
    logic                                            q_pop;
    logic [CMD_BITS-1:0]                             q_head;
    ucs_pkg::cmd_ctl_t                               head_ctl;
    logic [ucs_pkg::NUM_POS-1:0][POSITION_BITS-1:0]  head_pos;

    // lexer
    ucs_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .char_in  (char_in),
        .q_full   (q_full),
        .push     (push),
        .cmd_ctl  (front_ctl),
        .cmd_pos  (front_pos)
    );

    // command queue
    ucs_queue #(
        .DEPTH     (QUEUE_DEPTH),
        .DATA_BITS (CMD_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({front_ctl, front_pos}),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    assign head_ctl = q_head[CMD_BITS-1:POS_VEC_BITS];
    assign head_pos = q_head[POS_VEC_BITS-1:0];

    // token emitter
    ucs_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_not_empty),
        .cmd_pop      (q_pop),
        .cmd_ctl      (head_ctl),
        .cmd_pos      (head_pos),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_type   (token_type),
        .token_start  (token_start),
        .token_length (token_length),
        .overflow     (overflow),
        .last         (last)
    );

endmodule

`default_nettype wire

// ----- verif/url_token_checker.sv -----
// watches both channels of the url splitter, predicts the token descriptors
// of every accepted transaction and compares them in order
module url_token_checker
    import ucs_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  op,
    input  logic [7:0]            char_in,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [3:0]            token_type,
    input  logic [TOKEN_BITS-1:0] token_start,
    input  logic [TOKEN_BITS-1:0] token_length,
    input  logic                  overflow,
    input  logic                  last,
    output int                    tokens_due,
    output int                    error_count,
    output int                    tokens_checked
);

    typedef logic [POSITION_BITS-1:0] pos_t;

    localparam pos_t POS_MAX = '1;
    localparam int MAX_PRINTED = 20;

    typedef struct packed {
        token_type_t           kind;
        logic [TOKEN_BITS-1:0] start;
        logic [TOKEN_BITS-1:0] len;
        logic                  ovf;
        logic                  lst;
    } url_token_t;

    // tokens predicted but not yet seen on the result channel
    url_token_t pending_tokens[$];

    // lexer state of the prediction
    lex_mode_t mode;
    pos_t      byte_pos;
    pos_t      tok_begin;
    pos_t      auth_begin;
    logic      at_seen;
    pos_t      at_pos;
    logic      colon_seen;
    pos_t      colon_pos;
    logic      colon_at_seen;
    pos_t      colon_at_pos;
    logic      ovf_flag;

    initial
    begin
        error_count = 0;
        tokens_checked = 0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic pos_t bump(input pos_t x);
        return (x == POS_MAX) ? POS_MAX : x + 1'b1;
    endfunction

    task automatic clear_lexer();
        mode = MODE_SCHEME;
        byte_pos = '0;
        tok_begin = '0;
        auth_begin = '0;
        at_seen = 1'b0;
        at_pos = '0;
        colon_seen = 1'b0;
        colon_pos = '0;
        colon_at_seen = 1'b0;
        colon_at_pos = '0;
        ovf_flag = 1'b0;
    endtask

    task automatic push_token(input token_type_t kind, input pos_t b, input pos_t e);
        url_token_t t;
        t.kind = kind;
        t.start = TOKEN_BITS'(b);
        t.len = (e >= b) ? TOKEN_BITS'(e - b) : '0;
        t.ovf = ovf_flag;
        t.lst = 1'b0;
        pending_tokens = {pending_tokens, t};
    endtask

    // user, password, host and port from the recorded '@' and colon positions
    task automatic split_authority(input pos_t stop);
        pos_t hp_begin;
        pos_t hp_colon;
        logic hp_colon_seen;
        hp_begin = auth_begin;
        hp_colon_seen = colon_seen;
        hp_colon = colon_pos;
        if (at_seen)
        begin
            if (at_pos > auth_begin)
            begin
                if (colon_seen && colon_pos < at_pos)
                begin
                    push_token(TOK_USER, auth_begin, colon_pos);
                    push_token(TOK_PASSWORD, bump(colon_pos), at_pos);
                end
                else
                begin
                    push_token(TOK_USER, auth_begin, at_pos);
                end
            end
            hp_begin = bump(at_pos);
            hp_colon_seen = colon_at_seen;
            hp_colon = colon_at_pos;
        end
        if (hp_colon_seen)
        begin
            push_token(TOK_HOST, hp_begin, hp_colon);
            push_token(TOK_PORT, bump(hp_colon), stop);
        end
        else
        begin
            push_token(TOK_HOST, hp_begin, stop);
        end
    endtask

    // end mark: flush the open token and close with the end token
    task automatic close_url();
        case (mode)
            MODE_SCHEME:    push_token(TOK_SCHEME, '0, byte_pos);
            MODE_SLASH1:    push_token(TOK_PATH, tok_begin, bump(tok_begin));
            MODE_AUTHORITY: split_authority(byte_pos);
            MODE_PATH:      push_token(TOK_PATH, tok_begin, byte_pos);
            MODE_QUERY:     push_token(TOK_QUERY, tok_begin, byte_pos);
            MODE_FRAGMENT:  push_token(TOK_FRAGMENT, tok_begin, byte_pos);
            default:        ;
        endcase
        push_token(TOK_END, byte_pos, byte_pos);
    endtask

    task automatic take_byte(input logic [7:0] ch);
        pos_t here;
        pos_t next_pos;
        here = byte_pos;
        next_pos = bump(here);
        case (mode)
            MODE_SCHEME:
            begin
                if (ch == CH_COLON)
                begin
                    push_token(TOK_SCHEME, '0, here);
                    mode = MODE_AFTER_COLON;
                end
            end
            MODE_AFTER_COLON:
            begin
                if (ch == CH_SLASH)
                begin
                    mode = MODE_SLASH1;
                    tok_begin = here;
                end
                else if (ch == CH_QUESTION)
                begin
                    mode = MODE_QUERY;
                    tok_begin = next_pos;
                end
                else if (ch == CH_HASH)
                begin
                    mode = MODE_FRAGMENT;
                    tok_begin = next_pos;
                end
                else
                begin
                    mode = MODE_DEAD;
                end
            end
            MODE_SLASH1:
            begin
                if (ch == CH_SLASH)
                begin
                    mode = MODE_AUTHORITY;
                    auth_begin = next_pos;
                    at_seen = 1'b0;
                    at_pos = '0;
                    colon_seen = 1'b0;
                    colon_pos = '0;
                    colon_at_seen = 1'b0;
                    colon_at_pos = '0;
                end
                else if (ch == CH_QUESTION)
                begin
                    push_token(TOK_PATH, tok_begin, here);
                    mode = MODE_QUERY;
                    tok_begin = next_pos;
                end
                else if (ch == CH_HASH)
                begin
                    push_token(TOK_PATH, tok_begin, here);
                    mode = MODE_FRAGMENT;
                    tok_begin = next_pos;
                end
                else
                begin
                    mode = MODE_PATH;
                end
            end
            MODE_AUTHORITY:
            begin
                if (ch == CH_SLASH)
                begin
                    split_authority(here);
                    mode = MODE_PATH;
                    tok_begin = here;
                end
                else if (ch == CH_QUESTION)
                begin
                    split_authority(here);
                    mode = MODE_QUERY;
                    tok_begin = next_pos;
                end
                else if (ch == CH_HASH)
                begin
                    split_authority(here);
                    mode = MODE_FRAGMENT;
                    tok_begin = next_pos;
                end
                else if (ch == CH_AT)
                begin
                    at_seen = 1'b1;
                    at_pos = here;
                    colon_at_seen = 1'b0;
                    colon_at_pos = '0;
                end
                else if (ch == CH_COLON)
                begin
                    if (!colon_seen)
                    begin
                        colon_seen = 1'b1;
                        colon_pos = here;
                    end
                    if (at_seen && !colon_at_seen)
                    begin
                        colon_at_seen = 1'b1;
                        colon_at_pos = here;
                    end
                end
            end
            MODE_PATH:
            begin
                if (ch == CH_QUESTION)
                begin
                    push_token(TOK_PATH, tok_begin, here);
                    mode = MODE_QUERY;
                    tok_begin = next_pos;
                end
                else if (ch == CH_HASH)
                begin
                    push_token(TOK_PATH, tok_begin, here);
                    mode = MODE_FRAGMENT;
                    tok_begin = next_pos;
                end
            end
            MODE_QUERY:
            begin
                if (ch == CH_HASH)
                begin
                    push_token(TOK_QUERY, tok_begin, here);
                    mode = MODE_FRAGMENT;
                    tok_begin = next_pos;
                end
            end
            default: ;
        endcase
        // a byte at the saturated position flags the rest of the url
        if (here == POS_MAX)
        begin
            ovf_flag = 1'b1;
        end
        byte_pos = next_pos;
    endtask

    // predict the tokens of one input transaction and mark the last one
    task automatic tokenize_transaction(input logic op_v, input logic [7:0] ch);
        int n_before;
        n_before = pending_tokens.size();
        if (op_v == OP_END)
        begin
            close_url();
            clear_lexer();
        end
        else
        begin
            take_byte(ch);
        end
        if (pending_tokens.size() > n_before)
        begin
            pending_tokens[pending_tokens.size() - 1].lst = 1'b1;
        end
    endtask

    task automatic check_token();
        url_token_t want;
        if (pending_tokens.size() == 0)
        begin
            report_mismatch($sformatf("unexpected token type %0d start %0d length %0d",
                                      token_type, token_start, token_length));
        end
        else
        begin
            want = pending_tokens.pop_front();
            tokens_checked++;
            if (token_type !== want.kind)
                report_mismatch($sformatf("token_type got %0d want %0d",
                                          token_type, want.kind));
            if (token_start !== want.start)
                report_mismatch($sformatf("token_start got %0d want %0d (type %0d)",
                                          token_start, want.start, want.kind));
            if (token_length !== want.len)
                report_mismatch($sformatf("token_length got %0d want %0d (type %0d)",
                                          token_length, want.len, want.kind));
            if (overflow !== want.ovf)
                report_mismatch($sformatf("overflow got %0b want %0b (type %0d)",
                                          overflow, want.ovf, want.kind));
            if (last !== want.lst)
                report_mismatch($sformatf("last got %0b want %0b (type %0d)",
                                          last, want.lst, want.kind));
        end
    endtask

    // predict on accepted input, compare on accepted output
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_lexer();
            pending_tokens.delete();
            tokens_due <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                tokenize_transaction(op, char_in);
            end
            if (out_valid && !out_stall)
            begin
                check_token();
            end
            tokens_due <= pending_tokens.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
module testbench;
    import ucs_pkg::*;

    localparam int POS_BITS     = POSITION_BITS_DEFAULT;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 150;
    localparam int RANDOM_ITEMS = 320;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = OP_BYTE;
    logic [7:0] char_in = 8'h00;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] token_type;
    logic [TOKEN_BITS-1:0] token_start;
    logic [TOKEN_BITS-1:0] token_length;
    logic overflow;
    logic last;

    int tokens_due;
    int error_count;
    int tokens_checked;

    // stimulus bookkeeping
    int unsigned cycle_count = 0;
    int hold_requests = 0;
    logic holding = 1'b0;
    bit gaps_on = 1'b1;
    int items_sent = 0;
    int bytes_sent = 0;
    int urls_sent = 0;
    logic [7:0] url_buf[$];

    url_component_splitter #(
        .POSITION_BITS(POS_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .char_in(char_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .token_type(token_type),
        .token_start(token_start),
        .token_length(token_length),
        .overflow(overflow),
        .last(last)
    );

    url_token_checker #(
        .POSITION_BITS(POS_BITS)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .char_in(char_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .token_type(token_type),
        .token_start(token_start),
        .token_length(token_length),
        .overflow(overflow),
        .last(last),
        .tokens_due(tokens_due),
        .error_count(error_count),
        .tokens_checked(tokens_checked)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d tokens still due", cycle_count, tokens_due);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure: free-flowing stretches, short and long stalls,
    // and the requested long hold-off
    initial
    begin : stall_gen
        int holds_done;
        int pick;
        int stall_len;
        int flow_len;
        holds_done = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pick = $urandom_range(99, 0);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                stall_len = LONG_HOLD;
                flow_len = 1;
                holding <= 1'b1;
            end
            else if (pick < 30)
            begin
                stall_len = 0;
                flow_len = $urandom_range(40, 5);
            end
            else if (pick < 95)
            begin
                stall_len = $urandom_range(3, 1);
                flow_len = $urandom_range(4, 1);
            end
            else
            begin
                stall_len = $urandom_range(60, 20);
                flow_len = $urandom_range(4, 1);
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            holding <= 1'b0;
            repeat (flow_len) @(posedge clk);
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99, 0);
        if (!gaps_on || pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(3, 1);
        else if (pick < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // offer one transaction and wait until it is taken
    task automatic send_item(input logic op_v, input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= op_v;
        char_in <= ch;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (op_v == OP_BYTE)
            bytes_sent++;
        else
            urls_sent++;
    endtask

    task automatic send_end();
        send_item(OP_END, 8'($urandom_range(255, 0)));
    endtask

    task automatic send_url(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(OP_BYTE, s[i]);
        end
        send_end();
    endtask

    task automatic send_buffered_url();
        foreach (url_buf[i])
        begin
            send_item(OP_BYTE, url_buf[i]);
        end
        send_end();
        url_buf.delete();
    endtask

    // stop offering and let every predicted token come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // add one byte at the tail of the url being built
    task automatic append_byte(input logic [7:0] c);
        url_buf = {url_buf, c};
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255, 0));
        while (c == CH_SLASH || c == CH_QUESTION || c == CH_HASH || c == CH_AT || c == CH_COLON);
        return c;
    endfunction

    task automatic add_plain(input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) append_byte(plain_char());
    endtask

    // any byte at all, delimiters included
    task automatic add_any(input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        repeat (n) append_byte(8'($urandom_range(255, 0)));
    endtask

    // path body: mostly plain, sometimes '/', ':' or '@', which a path keeps
    task automatic add_path_body(input int lo, input int hi);
        int n;
        int pick;
        n = $urandom_range(hi, lo);
        repeat (n)
        begin
            pick = $urandom_range(19, 0);
            if (pick == 0)
                append_byte(CH_SLASH);
            else if (pick == 1)
                append_byte(CH_COLON);
            else if (pick == 2)
                append_byte(CH_AT);
            else
                append_byte(plain_char());
        end
    endtask

    task automatic add_userinfo();
        int pick;
        pick = $urandom_range(5, 0);
        if (pick == 2)
        begin
            add_plain(1, 4);
            append_byte(CH_AT);
        end
        else if (pick == 3)
        begin
            add_plain(0, 4);
            append_byte(CH_COLON);
            add_plain(0, 4);
            append_byte(CH_AT);
        end
        else if (pick == 4)
        begin
            append_byte(CH_AT);
        end
        else if (pick == 5)
        begin
            // several '@' and colons: the last '@' splits
            add_plain(0, 2);
            append_byte(CH_AT);
            add_plain(0, 2);
            append_byte(CH_COLON);
            add_plain(0, 2);
            append_byte(CH_AT);
            add_plain(0, 2);
            if ($urandom_range(1, 0))
                append_byte(CH_COLON);
            add_plain(0, 2);
            append_byte(CH_AT);
        end
    endtask

    // one random url: mostly well formed with random content, some noise
    task automatic build_random_url();
        int pick;
        bit with_path;
        url_buf.delete();
        if ($urandom_range(99, 0) < 12)
        begin
            add_any(0, 12);
            return;
        end
        add_plain(0, 5);
        if ($urandom_range(9, 0) == 0)
            return;
        append_byte(CH_COLON);
        with_path = 1'b0;
        pick = $urandom_range(9, 0);
        if (pick < 5)
        begin
            append_byte(CH_SLASH);
            append_byte(CH_SLASH);
            add_userinfo();
            add_plain(0, 4);
            if ($urandom_range(2, 0) == 0)
            begin
                append_byte(CH_COLON);
                add_plain(0, 3);
                if ($urandom_range(4, 0) == 0)
                    append_byte(CH_COLON);
            end
            with_path = 1'b1;
        end
        else if (pick < 7)
        begin
            append_byte(CH_SLASH);
            add_path_body(0, 6);
        end
        else if (pick == 7)
        begin
            append_byte(CH_QUESTION);
            add_plain(0, 5);
        end
        else if (pick == 8)
        begin
            append_byte(CH_HASH);
            add_any(0, 5);
            return;
        end
        else
        begin
            // unexpected byte after the scheme, rest ignored
            append_byte(plain_char());
            add_any(0, 6);
            return;
        end
        if (with_path && $urandom_range(1, 0))
        begin
            append_byte(CH_SLASH);
            add_path_body(0, 6);
        end
        if ($urandom_range(2, 0) == 0)
        begin
            append_byte(CH_QUESTION);
            add_plain(0, 5);
        end
        if ($urandom_range(2, 0) == 0)
        begin
            append_byte(CH_HASH);
            add_any(0, 5);
        end
    endtask

    initial
    begin : stimulus
        int random_start;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty url, every component, extreme bytes after the scheme,
        // empty user info, lone slash
        send_end();
        send_url("s://a:b@h:9/p?q#f");
        send_item(OP_BYTE, CH_COLON);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_end();
        send_url("://@h");
        send_url(":/");
        wait_idle();

        // long hold on the result side while the sender keeps offering
        hold_requests <= hold_requests + 1;
        @(posedge clk);
        while (!holding) @(posedge clk);
        gaps_on = 1'b0;
        repeat (8) send_url("p:?q#f");
        wait_idle();

        // random urls, pausing for a full drain now and then
        gaps_on = 1'b1;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            build_random_url();
            send_buffered_url();
            if ($urandom_range(19, 0) == 0)
                wait_idle();
        end
        wait_idle();

        $display("covered %0d urls, %0d bytes and %0d compared tokens", urls_sent, bytes_sent,
                 tokens_checked);
        $display("including a %0d-cycle output hold-off that backed up the command queue",
                 LONG_HOLD);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
